[sv/lls_pkg.sv]
// Shared types and codes for the least-loaded node selector.
`default_nettype none

package lls_pkg;

   // Operation codes carried on the request channel.
   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_CHOOSE = 2'd1;
   localparam logic [1:0] OP_CHECK  = 2'd2;

   // Fixed field widths.
   localparam int OP_W    = 2;
   localparam int TYPE_W  = 3;
   localparam int ID_W    = 4;
   localparam int LOAD_W  = 16;
   localparam int LIMIT_W = 12;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic capture;
      logic write_en;
      logic scan_step;
      logic result_load;
   } lls_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic            clear_last;
      logic            scan_last;
      logic [OP_W-1:0] op;
      logic            type_ok;
   } lls_stat_type;

endpackage

`default_nettype wire

[sv/lls_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lls_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 128
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/lls_ctrl.sv]
// Controller state machine for the least-loaded node selector.
`default_nettype none

module lls_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output lls_pkg::lls_cmd_type       cmd,
   input  wire lls_pkg::lls_stat_type stat
);

   import lls_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_WRITE,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when empty or being emptied.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (stat.op)
               OP_REPORT: state_in = S_WRITE;
               OP_CHOOSE, OP_CHECK: state_in = stat.type_ok ? S_SCAN : S_DONE;
               default: state_in = S_DONE;
            endcase
         end
         S_WRITE: begin
            cmd.write_en = 1'b1;
            state_in     = S_DONE;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last read word is folded in during this cycle.
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // State and registered response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[sv/lls_dpath.sv]
// Datapath for the least-loaded node selector: item registers, table, scan and result.
`default_nettype none

module lls_dpath #(
   parameter int NUM_TYPES      = 8,
   parameter int NODES_PER_TYPE = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lls_pkg::lls_cmd_type         cmd,
   output lls_pkg::lls_stat_type             stat,
   input  wire logic [lls_pkg::OP_W-1:0]     req_operation,
   input  wire logic [lls_pkg::TYPE_W-1:0]   req_node_type,
   input  wire logic [lls_pkg::ID_W-1:0]     req_node_id,
   input  wire logic [lls_pkg::LOAD_W-1:0]   req_load_value,
   input  wire logic [lls_pkg::LIMIT_W-1:0]  req_overload_limit,
   output logic      [lls_pkg::ID_W-1:0]     rsp_chosen_node,
   output logic                              rsp_found,
   output logic                              rsp_over_load
);

   import lls_pkg::*;

   localparam int ENTRIES = NUM_TYPES * NODES_PER_TYPE;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IDX_W   = (NODES_PER_TYPE > 1) ? $clog2(NODES_PER_TYPE) : 1;
   localparam int SUM_W   = LOAD_W + $clog2(NODES_PER_TYPE + 1);
   localparam int WORD_W  = LOAD_W + 1;

   // Latched item.
   logic [OP_W-1:0]    op_ff;
   logic [TYPE_W-1:0]  type_ff;
   logic [ID_W-1:0]    id_ff;
   logic [LOAD_W-1:0]  load_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Sequencing counters and read pipeline.
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_id_ff;

   // Accumulators.
   logic              any_ff, any_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [LOAD_W-1:0] best_load_ff, best_load_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // Result register.
   logic [ID_W-1:0] chosen_ff;
   logic            found_ff;
   logic            over_ff;

   logic              type_ok;
   logic              id_ok;
   logic [ADDR_W-1:0] base_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              rd_present;
   logic [LOAD_W-1:0] rd_load;

   // Range checks and table addressing.
   assign type_ok   = (32'(type_ff) < NUM_TYPES);
   assign id_ok     = (32'(id_ff) < NODES_PER_TYPE);
   assign base_addr = ADDR_W'(32'(type_ff) * NODES_PER_TYPE);
   assign rd_addr   = base_addr + ADDR_W'(scan_ff);

   // Write port serves the clearing pass after reset and report beats.
   always_comb begin
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.write_en && type_ok && id_ok;
         wr_addr = base_addr + ADDR_W'(id_ff);
         wr_data = {1'b1, load_ff};
      end
   end

   lls_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.scan_step),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_present = rd_data[WORD_W-1];
   assign rd_load    = rd_data[LOAD_W-1:0];

   // Counter and accumulator next values.
   always_comb begin
      clr_in       = cmd.clear_en ? clr_ff + 1'b1 : clr_ff;
      scan_in      = scan_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      best_load_in = best_load_ff;
      sum_in       = sum_ff;
      if (cmd.capture) begin
         scan_in = '0;
         any_in  = 1'b0;
         best_in = '0;
         sum_in  = '0;
      end else begin
         if (cmd.scan_step) begin
            scan_in = scan_ff + 1'b1;
         end
         // Fold in the word read on the previous cycle; strict compare keeps the lowest id.
         if (rd_valid_ff && rd_present) begin
            sum_in = sum_ff + SUM_W'(rd_load);
            if (!any_ff || (rd_load < best_load_ff)) begin
               any_in       = 1'b1;
               best_in      = rd_id_ff;
               best_load_in = rd_load;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         rd_valid_ff <= cmd.scan_step;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         type_ff  <= req_node_type;
         id_ff    <= req_node_id;
         load_ff  <= req_load_value;
         limit_ff <= req_overload_limit;
      end
      rd_id_ff     <= scan_ff;
      scan_ff      <= scan_in;
      any_ff       <= any_in;
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
      sum_ff       <= sum_in;
      if (cmd.result_load) begin
         chosen_ff <= (op_ff == OP_CHOOSE && any_ff) ? ID_W'(best_ff) : '0;
         found_ff  <= (op_ff == OP_CHOOSE) && any_ff;
         over_ff   <= (op_ff == OP_CHECK) && (32'(sum_ff >> 8) > 32'(limit_ff));
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.clear_last = (clr_ff == ADDR_W'(ENTRIES - 1));
      stat.scan_last  = (scan_ff == IDX_W'(NODES_PER_TYPE - 1));
      stat.op         = op_ff;
      stat.type_ok    = type_ok;
   end

   assign rsp_chosen_node = chosen_ff;
   assign rsp_found       = found_ff;
   assign rsp_over_load   = over_ff;

endmodule

`default_nettype wire

[sv/least_loaded_node_selector.sv]
// Top level of the least-loaded node selector.
`default_nettype none

// Usage:
// Request beats carry an operation: report writes one node's Q8.8 load into
// the table and marks it present; choose returns the least loaded present
// node of a type (lowest id on a tie); check flags a type whose integer load
// sum exceeds the given limit. Every request beat yields one response beat.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// One request is in work at a time. A report writes its entry without a
// scan; choose and check scan the type, reading one table entry per cycle
// from the single read port. A choose or check for an out-of-range type, or
// an unused code, skips the scan. The next request can be accepted in the
// same cycle that a response is presented. The response sits in an output
// register; the next request is accepted while it waits, and the block only
// holds its finished result back while the receiver stalls the previous
// one. After reset the block runs a clearing pass over the table, one entry
// per cycle over all NUM_TYPES * NODES_PER_TYPE entries, with req_stall high
// throughout.
module least_loaded_node_selector #(
   parameter int NUM_TYPES      = 8,
   parameter int NODES_PER_TYPE = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [lls_pkg::OP_W-1:0]     req_operation,
   input  wire logic [lls_pkg::TYPE_W-1:0]   req_node_type,
   input  wire logic [lls_pkg::ID_W-1:0]     req_node_id,
   input  wire logic [lls_pkg::LOAD_W-1:0]   req_load_value,
   input  wire logic [lls_pkg::LIMIT_W-1:0]  req_overload_limit,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [lls_pkg::ID_W-1:0]     rsp_chosen_node,
   output logic                              rsp_found,
   output logic                              rsp_over_load
);

   import lls_pkg::*;

   lls_cmd_type  cmd;
   lls_stat_type stat;

   // Sequencing.
   lls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table, scan and result registers.
   lls_dpath #(
      .NUM_TYPES      (NUM_TYPES),
      .NODES_PER_TYPE (NODES_PER_TYPE)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_node_type      (req_node_type),
      .req_node_id        (req_node_id),
      .req_load_value     (req_load_value),
      .req_overload_limit (req_overload_limit),
      .rsp_chosen_node    (rsp_chosen_node),
      .rsp_found          (rsp_found),
      .rsp_over_load      (rsp_over_load)
   );

`ifndef SYNTH
   // No request beat is taken while the table is being cleared.
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> req_stall)
      else $error("request accepted during clearing pass");

   // A new result never overwrites one the receiver is still stalling.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> !(rsp_valid && rsp_stall))
      else $error("pending response overwritten");

   // Controller commands are mutually exclusive.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_en, cmd.capture, cmd.write_en, cmd.scan_step, cmd.result_load}))
      else $error("more than one datapath command at once");

   // Loading a result always raises response valid on the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> rsp_valid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the least-loaded node selector with directed and random beats.
module tb;
   import lls_pkg::*;

   localparam int NUM_TYPES      = 8;
   localparam int NODES_PER_TYPE = 16;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PERCENT   = 28;
   localparam int DRAIN_CYCLES   = 2 * NODES_PER_TYPE + 10;

   typedef struct packed {
      logic [ID_W-1:0] chosen_node;
      logic            found;
      logic            over_load;
   } selection_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation      = '0;
   logic [TYPE_W-1:0]   req_node_type      = '0;
   logic [ID_W-1:0]     req_node_id        = '0;
   logic [LOAD_W-1:0]   req_load_value     = '0;
   logic [LIMIT_W-1:0]  req_overload_limit = '0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [ID_W-1:0]     rsp_chosen_node;
   logic                rsp_found;
   logic                rsp_over_load;

   // Shadow copy of the load table and its present marks.
   logic [LOAD_W-1:0]   node_load [NUM_TYPES][NODES_PER_TYPE];
   bit                  node_present [NUM_TYPES][NODES_PER_TYPE];

   selection_type       expected_selections [$];
   int                  error_count     = 0;
   bit                  sender_idles    = 1'b1;
   bit                  receiver_stalls = 1'b1;

   least_loaded_node_selector #(
      .NUM_TYPES      (NUM_TYPES),
      .NODES_PER_TYPE (NODES_PER_TYPE)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_node_type      (req_node_type),
      .req_node_id        (req_node_id),
      .req_load_value     (req_load_value),
      .req_overload_limit (req_overload_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_chosen_node    (rsp_chosen_node),
      .rsp_found          (rsp_found),
      .rsp_over_load      (rsp_over_load)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sum of the Q8.8 loads of the present nodes of one type.
   function automatic int unsigned type_load_sum(int unsigned node_type);
      int unsigned sum = 0;
      for (int n = 0; n < NODES_PER_TYPE; n++) begin
         if (node_present[node_type][n]) begin
            sum += node_load[node_type][n];
         end
      end
      return sum;
   endfunction

   // Applies one accepted request to the shadow table and returns its response.
   function automatic selection_type apply_request(logic [OP_W-1:0] op,
         logic [TYPE_W-1:0] node_type, logic [ID_W-1:0] node_id,
         logic [LOAD_W-1:0] load, logic [LIMIT_W-1:0] limit);
      selection_type     result    = '0;
      logic [LOAD_W-1:0] best_load = '0;
      case (op)
         OP_REPORT: begin
            if (node_type < NUM_TYPES && node_id < NODES_PER_TYPE) begin
               node_load[node_type][node_id]    = load;
               node_present[node_type][node_id] = 1'b1;
            end
         end
         OP_CHOOSE: begin
            // Strict less-than keeps the lowest id on a tie.
            if (node_type < NUM_TYPES) begin
               for (int n = 0; n < NODES_PER_TYPE; n++) begin
                  if (node_present[node_type][n] &&
                      (!result.found || node_load[node_type][n] < best_load)) begin
                     result.chosen_node = ID_W'(n);
                     result.found       = 1'b1;
                     best_load          = node_load[node_type][n];
                  end
               end
            end
         end
         OP_CHECK: begin
            // Only the integer part of the Q8.8 sum is compared.
            if (node_type < NUM_TYPES) begin
               result.over_load = (type_load_sum(node_type) >> 8) > limit;
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endfunction

   // The receiver stalls at random while stalling is enabled.
   always @(negedge clock) begin
      rsp_stall <= receiver_stalls && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Every response beat is compared with the oldest expected selection.
   always @(posedge clock) begin
      selection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_selections.size() == 0) begin
            $error("Unexpected response beat: chosen_node %0d found %0b over_load %0b",
                   rsp_chosen_node, rsp_found, rsp_over_load);
            error_count++;
         end else begin
            want = expected_selections.pop_front();
            check_field("chosen_node", 16'(want.chosen_node), 16'(rsp_chosen_node));
            check_field("found", 16'(want.found), 16'(rsp_found));
            check_field("over_load", 16'(want.over_load), 16'(rsp_over_load));
         end
      end
   end

   // Sends one request beat; called and returning at a falling edge.
   task automatic send_request(logic [OP_W-1:0] op, logic [TYPE_W-1:0] node_type,
         logic [ID_W-1:0] node_id, logic [LOAD_W-1:0] load, logic [LIMIT_W-1:0] limit);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_node_type      <= node_type;
      req_node_id        <= node_id;
      req_load_value     <= load;
      req_overload_limit <= limit;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      expected_selections.push_back(apply_request(op, node_type, node_id, load, limit));
      @(negedge clock);
   endtask

   // Loads mix full-range values, small values and a few codes that tie often.
   function automatic logic [LOAD_W-1:0] random_load();
      case ($urandom_range(3))
         0: return LOAD_W'($urandom);
         1: return LOAD_W'($urandom_range(1023));
         2: return LOAD_W'($urandom_range(3) << 7);
         default: return ($urandom_range(1) != 0) ? {LOAD_W{1'b1}} : {LOAD_W{1'b0}};
      endcase
   endfunction

   // Choose, check and an unused code on a table that has no present node yet.
   task automatic test_empty_table();
      send_request(OP_CHOOSE, 3'd0, 4'd0, 16'h0000, 12'd0);
      send_request(OP_CHOOSE, 3'd7, 4'd15, 16'hFFFF, 12'd4095);
      send_request(OP_CHECK, 3'd0, 4'd0, 16'h0000, 12'd0);
      send_request(OP_CHECK, 3'd7, 4'd15, 16'hFFFF, 12'd0);
      send_request(OP_UNUSED, 3'd7, 4'd15, 16'hFFFF, 12'd4095);
   endtask

   // Field extremes, ties, overwrites, an unused code, limits at and below the integer sum.
   task automatic test_directed();
      send_request(OP_REPORT, 3'd0, 4'd0, 16'h0000, 12'd0);
      send_request(OP_CHOOSE, 3'd0, 4'd0, 16'h0000, 12'd0);
      send_request(OP_REPORT, 3'd2, 4'd15, 16'hFFFF, 12'd4095);
      send_request(OP_CHOOSE, 3'd2, 4'd0, 16'h0000, 12'd0);
      send_request(OP_CHECK, 3'd2, 4'd0, 16'h0000, 12'd254);
      send_request(OP_CHECK, 3'd2, 4'd0, 16'h0000, 12'd255);
      send_request(OP_REPORT, 3'd2, 4'd0, 16'hFFFF, 12'd0);
      send_request(OP_CHOOSE, 3'd2, 4'd0, 16'h0000, 12'd0);
      send_request(OP_REPORT, 3'd2, 4'd7, 16'h0000, 12'd0);
      send_request(OP_CHOOSE, 3'd2, 4'd0, 16'h0000, 12'd0);
      send_request(OP_REPORT, 3'd2, 4'd7, 16'h0001, 12'd0);
      send_request(OP_REPORT, 3'd2, 4'd3, 16'h0001, 12'd0);
      send_request(OP_CHOOSE, 3'd2, 4'd0, 16'h0000, 12'd0);
      send_request(OP_CHECK, 3'd2, 4'd0, 16'h0000, 12'd510);
      send_request(OP_CHECK, 3'd2, 4'd0, 16'h0000, 12'd511);
      send_request(OP_CHECK, 3'd2, 4'd0, 16'h0000, 12'd4095);
      send_request(OP_UNUSED, 3'd2, 4'd3, 16'h1234, 12'd0);
      send_request(OP_CHOOSE, 3'd2, 4'd0, 16'h0000, 12'd0);
   endtask

   // Random traffic; check limits cluster around the current integer sum.
   task automatic test_random_traffic(int beats);
      logic [OP_W-1:0]    op;
      logic [TYPE_W-1:0]  node_type;
      logic [LIMIT_W-1:0] limit;
      int unsigned        pick;
      int unsigned        sum_int;
      for (int i = 0; i < beats; i++) begin
         pick      = $urandom_range(99);
         node_type = TYPE_W'($urandom);
         op        = (pick < 45) ? OP_REPORT : (pick < 70) ? OP_CHOOSE :
                     (pick < 95) ? OP_CHECK : OP_UNUSED;
         sum_int   = type_load_sum(node_type) >> 8;
         case ($urandom_range(2))
            0: limit = LIMIT_W'($urandom);
            1: limit = LIMIT_W'(sum_int);
            default: limit = LIMIT_W'(sum_int + $urandom_range(2) - 1);
         endcase
         send_request(op, node_type, ID_W'($urandom), random_load(), limit);
      end
   endtask

   // The same traffic with neither side idling.
   task automatic test_back_to_back(int beats);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(beats);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_selections.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed();
      test_random_traffic(600);
      test_back_to_back(300);
      test_random_traffic(300);
      drain_responses();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
